// ===== design/lcgsa_pkg.sv =====
// Shared constants and types for the multi-stream LCG with skip-ahead.
package lcgsa_pkg;

   localparam int SEED_W = 63;
   localparam int CFG_W = 64;
   localparam int OPC_W = 3;
   localparam int SIDX_W = 3;
   localparam int CSR_IDX_W = 1;
   localparam int NUM_STREAMS_DEFAULT = 5;

   localparam logic [SEED_W-1:0] LCG_MULT = 63'd2806196910506780709;
   localparam logic [SEED_W-1:0] LCG_INC = 63'd1;
   localparam logic [CFG_W-1:0] BASE_SEED_RESET = 64'd1;
   localparam logic [SEED_W-1:0] STRIDE_RESET = 63'd152917;

   localparam logic [OPC_W-1:0] OP_NEXT = 3'd0;
   localparam logic [OPC_W-1:0] OP_PEEK = 3'd1;
   localparam logic [OPC_W-1:0] OP_ADVANCE = 3'd2;
   localparam logic [OPC_W-1:0] OP_SEED = 3'd3;
   localparam logic [OPC_W-1:0] OP_RELOAD = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE_SEED = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STRIDE = 1'd1;

   typedef struct packed {
      logic start;
      logic [SEED_W-1:0] mult_a;
      logic [SEED_W-1:0] mult_b;
      logic [SEED_W-1:0] addend;
   } mac_req_type;

   typedef struct packed {
      logic done;
      logic [SEED_W-1:0] result;
   } mac_rsp_type;

endpackage

// ===== design/multi_stream_lcg_with_skip_ahead.sv =====
// Top level: stream state, configuration registers and the skip-ahead sequencer.
//
//   Channel  Direction  Handshake            Payload
//   req      in         req_valid/req_ready  req_opcode, req_stream_index, req_count
//   rsp      out        rsp_valid/rsp_ready  rsp_value
//   csr      in         csr_wr_en            csr_index, csr_wdata
//
// Every multiply goes through one shared multiply-add unit. A skip uses two multiply-adds
// for each set bit of the count, two for each bit below its highest set bit and one to
// apply, at most 251 uses. A particle seed uses one more for the distance and one per
// stream in place of the last.
// Reset is synchronous and restores the streams to one plus their index.
// A result held in rsp blocks only the finishing step of the next transaction.
module multi_stream_lcg_with_skip_ahead #(
   parameter int NUM_STREAMS = lcgsa_pkg::NUM_STREAMS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [lcgsa_pkg::OPC_W-1:0]      req_opcode,
   input  logic [lcgsa_pkg::SIDX_W-1:0]     req_stream_index,
   input  logic signed [lcgsa_pkg::CFG_W-1:0] req_count,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [lcgsa_pkg::SEED_W-1:0]     rsp_value,
   input  logic                             csr_wr_en,
   input  logic [lcgsa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lcgsa_pkg::CFG_W-1:0]      csr_wdata
);

   localparam int IDX_W = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
   localparam int SW = lcgsa_pkg::SEED_W;

   typedef enum logic [9:0] {
      ST_IDLE    = 10'b0000000001,
      ST_NEXT    = 10'b0000000010,
      ST_DIST    = 10'b0000000100,
      ST_ACCG    = 10'b0000001000,
      ST_ACCC    = 10'b0000010000,
      ST_SQC     = 10'b0000100000,
      ST_SQG     = 10'b0001000000,
      ST_APPLY   = 10'b0010000000,
      ST_SEEDALL = 10'b0100000000,
      ST_FINISH  = 10'b1000000000
   } state_type;

   localparam logic [9:0] MAC_STATES = ST_NEXT | ST_DIST | ST_ACCG | ST_ACCC | ST_SQC |
                                       ST_SQG | ST_APPLY | ST_SEEDALL;

   state_type                       state_ff, state_in;
   logic                            pend_ff, pend_in;
   logic [lcgsa_pkg::OPC_W-1:0]     op_ff, op_in;
   logic [lcgsa_pkg::SIDX_W-1:0]    sidx_ff, sidx_in;
   logic                            sidx_ok_ff, sidx_ok_in;
   logic [SW-1:0]                   k_ff, k_in;
   logic [SW-1:0]                   g_ff, g_in;
   logic [SW-1:0]                   c_ff, c_in;
   logic [SW-1:0]                   accg_ff, accg_in;
   logic [SW-1:0]                   accc_ff, accc_in;
   logic [SW-1:0]                   res_ff, res_in;
   logic [IDX_W-1:0]                cnt_ff, cnt_in;
   logic [SW-1:0]                   seeds_ff [NUM_STREAMS];
   logic [SW-1:0]                   seeds_in [NUM_STREAMS];
   logic [lcgsa_pkg::CFG_W-1:0]     base_seed_ff, base_seed_in;
   logic [SW-1:0]                   stride_ff, stride_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0]                   rsp_value_ff, rsp_value_in;
   logic [IDX_W-1:0]                rd_idx, wr_idx;
   logic [SW-1:0]                   seed_rd;
   logic [SW-1:0]                   stream_base;
   logic                            mac_start, mac_fin;
   lcgsa_pkg::mac_req_type          mac_req;
   lcgsa_pkg::mac_rsp_type          mac_rsp;

   function automatic state_type loop_entry(input logic [SW-1:0] k, input logic seed_op);
      state_type nxt;
      if (k == '0) begin
         nxt = seed_op ? ST_SEEDALL : ST_APPLY;
      end else if (k[0]) begin
         nxt = ST_ACCG;
      end else begin
         nxt = ST_SQC;
      end
      return nxt;
   endfunction

   lcgsa_mac u_mac (
      .clock (clock),
      .reset (reset),
      .req   (mac_req),
      .rsp   (mac_rsp)
   );

   always_comb begin
      rd_idx = IDX_W'(sidx_ff);
      wr_idx = (state_ff == ST_SEEDALL) ? cnt_ff : rd_idx;
      seed_rd = seeds_ff[rd_idx];
      stream_base = base_seed_ff[SW-1:0] + SW'(cnt_ff);
      mac_start = ((state_ff & MAC_STATES) != '0) && !pend_ff;
      mac_fin = pend_ff && mac_rsp.done;
   end

   always_comb begin
      mac_req.start = mac_start;
      mac_req.mult_a = '0;
      mac_req.mult_b = '0;
      mac_req.addend = '0;
      case (state_ff)
         ST_NEXT: begin
            mac_req.mult_a = lcgsa_pkg::LCG_MULT;
            mac_req.mult_b = seed_rd;
            mac_req.addend = lcgsa_pkg::LCG_INC;
         end
         ST_DIST: begin
            mac_req.mult_a = k_ff;
            mac_req.mult_b = stride_ff;
         end
         ST_ACCG: begin
            mac_req.mult_a = accg_ff;
            mac_req.mult_b = g_ff;
         end
         ST_ACCC: begin
            mac_req.mult_a = accc_ff;
            mac_req.mult_b = g_ff;
            mac_req.addend = c_ff;
         end
         ST_SQC: begin
            mac_req.mult_a = g_ff + SW'(1);
            mac_req.mult_b = c_ff;
         end
         ST_SQG: begin
            mac_req.mult_a = g_ff;
            mac_req.mult_b = g_ff;
         end
         ST_APPLY: begin
            mac_req.mult_a = accg_ff;
            mac_req.mult_b = seed_rd;
            mac_req.addend = accc_ff;
         end
         ST_SEEDALL: begin
            mac_req.mult_a = accg_ff;
            mac_req.mult_b = stream_base;
            mac_req.addend = accc_ff;
         end
         default: begin
            mac_req.mult_a = '0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      pend_in = mac_start ? 1'b1 : (mac_fin ? 1'b0 : pend_ff);
      op_in = op_ff;
      sidx_in = sidx_ff;
      sidx_ok_in = sidx_ok_ff;
      k_in = k_ff;
      g_in = g_ff;
      c_in = c_ff;
      accg_in = accg_ff;
      accc_in = accc_ff;
      res_in = res_ff;
      cnt_in = cnt_ff;
      seeds_in = seeds_ff;
      base_seed_in = base_seed_ff;
      stride_in = stride_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;

      if (csr_wr_en) begin
         case (csr_index)
            lcgsa_pkg::CSR_BASE_SEED: base_seed_in = csr_wdata;
            lcgsa_pkg::CSR_STRIDE: stride_in = csr_wdata[SW-1:0];
            default: stride_in = stride_ff;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in = req_opcode;
               sidx_in = req_stream_index;
               sidx_ok_in = (32'(req_stream_index) < 32'(NUM_STREAMS));
               k_in = req_count[SW-1:0];
               g_in = lcgsa_pkg::LCG_MULT;
               c_in = lcgsa_pkg::LCG_INC;
               accg_in = SW'(1);
               accc_in = '0;
               cnt_in = '0;
               state_in = ST_FINISH;
               if (sidx_ok_in && req_opcode == lcgsa_pkg::OP_NEXT) begin
                  state_in = ST_NEXT;
               end else if (sidx_ok_in && (req_opcode == lcgsa_pkg::OP_PEEK ||
                                          req_opcode == lcgsa_pkg::OP_ADVANCE)) begin
                  state_in = loop_entry(req_count[SW-1:0], 1'b0);
               end else if (req_opcode == lcgsa_pkg::OP_SEED) begin
                  state_in = ST_DIST;
               end else if (req_opcode == lcgsa_pkg::OP_RELOAD) begin
                  for (int i = 0; i < NUM_STREAMS; i++) begin
                     seeds_in[i] = base_seed_ff[SW-1:0] + SW'(i);
                  end
               end
            end
         end
         ST_NEXT: begin
            if (mac_fin) begin
               seeds_in[wr_idx] = mac_rsp.result;
               state_in = ST_FINISH;
            end
         end
         ST_DIST: begin
            if (mac_fin) begin
               k_in = mac_rsp.result;
               state_in = loop_entry(mac_rsp.result, 1'b1);
            end
         end
         ST_ACCG: begin
            if (mac_fin) begin
               accg_in = mac_rsp.result;
               state_in = ST_ACCC;
            end
         end
         ST_ACCC: begin
            if (mac_fin) begin
               accc_in = mac_rsp.result;
               if (k_ff[SW-1:1] == '0) begin
                  state_in = (op_ff == lcgsa_pkg::OP_SEED) ? ST_SEEDALL : ST_APPLY;
               end else begin
                  state_in = ST_SQC;
               end
            end
         end
         ST_SQC: begin
            if (mac_fin) begin
               c_in = mac_rsp.result;
               state_in = ST_SQG;
            end
         end
         ST_SQG: begin
            if (mac_fin) begin
               g_in = mac_rsp.result;
               k_in = {1'b0, k_ff[SW-1:1]};
               state_in = k_ff[1] ? ST_ACCG : ST_SQC;
            end
         end
         ST_APPLY: begin
            if (mac_fin) begin
               res_in = mac_rsp.result;
               if (op_ff == lcgsa_pkg::OP_ADVANCE) begin
                  seeds_in[wr_idx] = mac_rsp.result;
               end
               state_in = ST_FINISH;
            end
         end
         ST_SEEDALL: begin
            if (mac_fin) begin
               seeds_in[wr_idx] = mac_rsp.result;
               if (cnt_ff == IDX_W'(NUM_STREAMS - 1)) begin
                  state_in = ST_FINISH;
               end else begin
                  cnt_in = cnt_ff + IDX_W'(1);
               end
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               if (!sidx_ok_ff) begin
                  rsp_value_in = '0;
               end else if (op_ff == lcgsa_pkg::OP_PEEK) begin
                  rsp_value_in = res_ff;
               end else begin
                  rsp_value_in = seed_rd;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         base_seed_ff <= lcgsa_pkg::BASE_SEED_RESET;
         stride_ff <= lcgsa_pkg::STRIDE_RESET;
         for (int i = 0; i < NUM_STREAMS; i++) begin
            seeds_ff[i] <= lcgsa_pkg::BASE_SEED_RESET[SW-1:0] + SW'(i);
         end
      end else begin
         state_ff <= state_in;
         pend_ff <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         base_seed_ff <= base_seed_in;
         stride_ff <= stride_in;
         seeds_ff <= seeds_in;
      end
      op_ff <= op_in;
      sidx_ff <= sidx_in;
      sidx_ok_ff <= sidx_ok_in;
      k_ff <= k_in;
      g_ff <= g_in;
      c_ff <= c_in;
      accg_ff <= accg_in;
      accc_ff <= accc_in;
      res_ff <= res_in;
      cnt_ff <= cnt_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

endmodule

// ===== design/lcgsa_mac.sv =====
// Shared multiply-add unit: a * b + addend modulo 2^63 over one 32x32 multiplier.
module lcgsa_mac (
   input  logic                  clock,
   input  logic                  reset,
   input  lcgsa_pkg::mac_req_type req,
   output lcgsa_pkg::mac_rsp_type rsp
);

   typedef enum logic [3:0] {
      PH_LOW_LOW  = 4'b0001,
      PH_LOW_HIGH = 4'b0010,
      PH_HIGH_LOW = 4'b0100,
      PH_LAST     = 4'b1000
   } phase_type;

   logic                         busy_ff, busy_in;
   phase_type                    phase_ff, phase_in;
   logic                         done_ff, done_in;
   logic [lcgsa_pkg::SEED_W-1:0] a_ff, a_in;
   logic [lcgsa_pkg::SEED_W-1:0] b_ff, b_in;
   logic [lcgsa_pkg::SEED_W-1:0] add_ff, add_in;
   logic [lcgsa_pkg::SEED_W-1:0] acc_ff, acc_in;
   logic [63:0]                  prod_ff, prod_in;
   logic [31:0]                  op_a, op_b;
   logic [63:0]                  mul_out;

   always_comb begin
      op_a = (phase_ff == PH_HIGH_LOW) ? {1'b0, a_ff[62:32]} : a_ff[31:0];
      op_b = (phase_ff == PH_LOW_HIGH) ? {1'b0, b_ff[62:32]} : b_ff[31:0];
      mul_out = 64'(op_a) * 64'(op_b);
   end

   always_comb begin
      busy_in = busy_ff;
      phase_in = phase_ff;
      done_in = 1'b0;
      a_in = a_ff;
      b_in = b_ff;
      add_in = add_ff;
      acc_in = acc_ff;
      prod_in = prod_ff;
      if (req.start) begin
         busy_in = 1'b1;
         phase_in = PH_LOW_LOW;
         a_in = req.mult_a;
         b_in = req.mult_b;
         add_in = req.addend;
      end else if (busy_ff) begin
         case (phase_ff)
            PH_LOW_LOW: begin
               prod_in = mul_out;
               phase_in = PH_LOW_HIGH;
            end
            PH_LOW_HIGH: begin
               acc_in = prod_ff[62:0] + add_ff;
               prod_in = mul_out;
               phase_in = PH_HIGH_LOW;
            end
            PH_HIGH_LOW: begin
               acc_in = acc_ff + {prod_ff[30:0], 32'b0};
               prod_in = mul_out;
               phase_in = PH_LAST;
            end
            default: begin
               acc_in = acc_ff + {prod_ff[30:0], 32'b0};
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         phase_ff <= PH_LOW_LOW;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         phase_ff <= phase_in;
         done_ff <= done_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      add_ff <= add_in;
      acc_ff <= acc_in;
      prod_ff <= prod_in;
   end

   assign rsp.done = done_ff;
   assign rsp.result = acc_ff;

endmodule
